>>> src/hwrsi_pkg.sv
package hwrsi_pkg;

  // Q30 pi for the window weight sine series
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Taylor series divisors (2n)(2n+1), n = 1..8
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam int unsigned QUOT_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } hwrsi_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } hwrsi_div_stat_t;

endpackage

>>> src/hwrsi_div.sv
module hwrsi_div #(
  parameter int unsigned SUM_W = 47
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [SUM_W-1:0]         up_sum,
  input  logic [SUM_W-1:0]         dn_sum,
  output logic [15:0]              quot,
  output hwrsi_pkg::hwrsi_div_stat_t stat
);
  import hwrsi_pkg::*;

  localparam int unsigned DEN_W = SUM_W + 1;
  localparam int unsigned REM_W = SUM_W + 2;
  localparam int unsigned CNT_W = $clog2(QUOT_BITS + 1);

  logic [DEN_W-1:0] den_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [15:0]      quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic             neg_r;
  logic             zero_r;
  logic [DEN_W-1:0] den_sum;
  logic             up_lt_dn;
  logic             ge;

  assign den_sum  = DEN_W'(up_sum) + DEN_W'(dn_sum);
  assign up_lt_dn = up_sum < dn_sum;
  assign ge       = rem_r >= REM_W'(den_r);

  always_comb begin
    rem_nxt = ge ? (rem_r - REM_W'(den_r)) : rem_r;
    rem_nxt = rem_nxt << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den_sum;
      rem_r  <= up_lt_dn ? REM_W'(dn_sum - up_sum) : REM_W'(up_sum - dn_sum);
      neg_r  <= up_lt_dn;
      zero_r <= den_sum == '0;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[14:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.done = done_r;
  assign stat.neg  = neg_r;
  assign stat.zero = zero_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUOT_BITS))
    else $error("divider step count out of range");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(run_r))
    else $error("divider done without a running division");

endmodule

>>> src/hann_windowed_rsi.sv
// Channel  Ports                        Width      Direction
// in       in_valid/in_stall            24 price   request in, stall out
// out      out_valid/out_stall          16 + 1     request out, stall in
//
// Each item makes one history memory read per window tap, then passes three
// pipe stages to the sums and a 16-step restoring divide. Reset is synchronous;
// history reads as zero until filled, tracked by the fill count, so no
// clearing pass. A result waits in the output register under out_stall while
// the next price is already accepted.
module hann_windowed_rsi #(
  parameter int unsigned WINDOW_LENGTH = 20,
  parameter int unsigned PRICE_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PRICE_BITS-1:0] in_close_price,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_rsih_value,
  output logic                  out_window_full
);
  import hwrsi_pkg::*;

  localparam int unsigned HIST_DEPTH = WINDOW_LENGTH + 1;
  localparam int unsigned AW     = $clog2(HIST_DEPTH);
  localparam int unsigned FW     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned KW     = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned KIW    = $clog2(WINDOW_LENGTH);
  localparam int unsigned PROD_W = PRICE_BITS + 17;
  localparam int unsigned SUM_W  = PROD_W + $clog2(WINDOW_LENGTH);

  function automatic logic [16:0] hann_weight(input int unsigned k);
    logic [63:0] m;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] us;
    longint      s;
    begin
      m     = (2 * k <= HIST_DEPTH) ? 64'(k) : 64'(HIST_DEPTH - k);
      theta = (PI_Q30 * m + 64'(HIST_DEPTH / 2)) / 64'(HIST_DEPTH);
      t2    = (theta * theta) >> 30;
      term  = theta;
      s     = longint'(theta);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * t2) >> 30) / TAYLOR_DIV[n-1];
        if (n % 2 == 1) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      us = 64'(s);
      hann_weight = 17'((us * us + (64'd1 << 43)) >> 44);
    end
  endfunction

  logic [16:0] weight_tab [WINDOW_LENGTH];

  for (genvar gk = 0; gk < WINDOW_LENGTH; gk++) begin : g_wt
    assign weight_tab[gk] = hann_weight(gk + 1);
  end

  hwrsi_state_t state_r, state_nxt;

  logic accept;
  logic div_start;
  logic out_load;

  // history memory, circular with head_r at the newest price
  logic [PRICE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [PRICE_BITS-1:0] rd_data_r;
  logic [AW-1:0]         head_r;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr_r;
  logic [FW-1:0]         fill_r;

  logic          issue_r;
  logic [KW-1:0] k_r;

  logic                  s1_v_r, s1_last_r;
  logic [KW-1:0]         s1_k_r;
  logic [PRICE_BITS-1:0] cur_r;
  logic [PRICE_BITS-1:0] older;
  logic [KIW-1:0]        w_idx;

  logic                  s2_v_r, s2_last_r, s2_up_r, s2_dn_r;
  logic [PRICE_BITS-1:0] s2_mag_r;
  logic [16:0]           s2_w_r;

  logic              s3_v_r, s3_last_r, s3_up_r, s3_dn_r;
  logic [PROD_W-1:0] prod_r;

  logic [SUM_W-1:0] up_r, dn_r;

  logic [15:0]      quot;
  hwrsi_div_stat_t  div_stat;
  logic [15:0]      result;

  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic        out_full_r;

  assign accept  = in_valid && !in_stall;
  assign wr_addr = (head_r == AW'(HIST_DEPTH - 1)) ? '0 : head_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (s3_v_r && s3_last_r) state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) hist_mem[wr_addr] <= in_close_price;
    rd_data_r <= hist_mem[rd_addr_r];
  end

  // tap read issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      issue_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      s1_v_r <= issue_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (accept) begin
        head_r  <= wr_addr;
        issue_r <= 1'b1;
        if (fill_r != FW'(HIST_DEPTH)) fill_r <= fill_r + FW'(1);
      end else if (issue_r && k_r == KW'(WINDOW_LENGTH)) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r <= head_r;
      k_r       <= KW'(1);
    end else if (issue_r) begin
      rd_addr_r <= (rd_addr_r == '0) ? AW'(HIST_DEPTH - 1) : rd_addr_r - AW'(1);
      k_r       <= k_r + KW'(1);
    end
    s1_k_r    <= k_r;
    s1_last_r <= k_r == KW'(WINDOW_LENGTH);
  end

  // unfilled history entries read as zero
  assign older = (FW'(s1_k_r) < fill_r) ? rd_data_r : '0;
  assign w_idx = KIW'(s1_k_r - KW'(1));

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= in_close_price;
      up_r  <= '0;
      dn_r  <= '0;
    end else begin
      if (s1_v_r) cur_r <= older;
      if (s3_v_r && s3_up_r) up_r <= up_r + SUM_W'(prod_r);
      if (s3_v_r && s3_dn_r) dn_r <= dn_r + SUM_W'(prod_r);
    end
    s2_up_r   <= cur_r > older;
    s2_dn_r   <= cur_r < older;
    s2_mag_r  <= (cur_r > older) ? cur_r - older : older - cur_r;
    s2_w_r    <= weight_tab[w_idx];
    s2_last_r <= s1_last_r;
    prod_r    <= PROD_W'(s2_w_r) * PROD_W'(s2_mag_r);
    s3_up_r   <= s2_up_r;
    s3_dn_r   <= s2_dn_r;
    s3_last_r <= s2_last_r;
  end

  hwrsi_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .up_sum (up_r),
    .dn_sum (dn_r),
    .quot   (quot),
    .stat   (div_stat)
  );

  always_comb begin
    if (div_stat.zero) result = '0;
    else if (div_stat.neg) result = 16'(17'd0 - 17'(quot));
    else if (quot[15]) result = 16'h7fff;
    else result = quot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= result;
      out_full_r  <= fill_r == FW'(HIST_DEPTH);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rsih_value  = out_value_r;
  assign out_window_full = out_full_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HIST_DEPTH))
    else $error("fill count past history depth");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> fill_r == FW'(HIST_DEPTH))
    else $error("window full flag without full history");

endmodule

>>> bench/rsi_checker.sv
`timescale 1ns / 100ps

module rsi_checker #(
  parameter int unsigned WIN_LEN = 20,
  parameter int unsigned PRICE_W = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [PRICE_W-1:0]  in_close_price,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [15:0]  out_rsih_value,
  input  logic                out_window_full,
  output int                  fail_count,
  output int                  pending_count
);

  localparam longint unsigned PI_Q30_RAD = 64'd3373259426;
  localparam logic signed [15:0] RSI_MAX = 16'sd32767;

  typedef struct packed {
    logic signed [15:0] rsih;
    logic               full;
  } rsi_result_t;

  rsi_result_t       expected_rsi_q[$];
  logic [PRICE_W-1:0] price_hist [0:WIN_LEN];
  int unsigned       prices_seen;
  longint unsigned   hann_w [1:WIN_LEN];
  int                checked_count;

  // sin^2(pi*k/(L+1)) in Q16 via a truncating Taylor series in Q30
  function automatic longint unsigned hann_weight(input int unsigned k);
    longint unsigned n1, m, theta, t2, term, us;
    longint          s;
    n1 = WIN_LEN + 1;
    m = (2 * k <= n1) ? k : n1 - k;
    theta = (PI_Q30_RAD * m + n1 / 2) / n1;
    t2 = (theta * theta) >> 30;
    term = theta;
    s = longint'(theta);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    us = longint'(s);
    return (us * us + (64'd1 << 43)) >> 44;
  endfunction

  initial begin
    for (int k = 1; k <= WIN_LEN; k++) hann_w[k] = hann_weight(k);
    fail_count = 0;
    pending_count = 0;
    checked_count = 0;
    prices_seen = 0;
    for (int i = 0; i <= WIN_LEN; i++) price_hist[i] = '0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t MISMATCH %s: got %0d, expected %0d (result %0d)",
             $time, what, got, want, checked_count);
    fail_count++;
  endtask

  task automatic predict_rsi(input logic [PRICE_W-1:0] price);
    logic [127:0]        up, dn, den, num, rem;
    logic [16:0]         quo;
    logic                neg;
    rsi_result_t         res;
    up = '0;
    dn = '0;
    for (int k = WIN_LEN; k > 0; k--) price_hist[k] = price_hist[k-1];
    price_hist[0] = price;
    if (prices_seen < WIN_LEN + 1) prices_seen++;

    for (int k = 1; k <= WIN_LEN; k++) begin
      if (price_hist[k-1] > price_hist[k])
        up += hann_w[k] * (price_hist[k-1] - price_hist[k]);
      else if (price_hist[k-1] < price_hist[k])
        dn += hann_w[k] * (price_hist[k] - price_hist[k-1]);
    end

    den = up + dn;
    if (den == '0) begin
      res.rsih = '0;
    end else begin
      neg = (up < dn);
      num = neg ? dn - up : up - dn;
      rem = num;
      quo = '0;
      for (int i = 0; i < 16; i++) begin
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo[0] = 1'b1;
        end
        rem = rem << 1;
      end
      if (neg) res.rsih = 16'(-quo);
      else if (quo > 17'd32767) res.rsih = RSI_MAX;
      else res.rsih = 16'(quo);
    end
    res.full = (prices_seen >= WIN_LEN + 1);
    expected_rsi_q.push_back(res);
  endtask

  always @(posedge clk) begin
    rsi_result_t want;
    if (!rst_n) begin
      expected_rsi_q.delete();
      for (int i = 0; i <= WIN_LEN; i++) price_hist[i] = '0;
      prices_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsi_q.size() == 0) begin
          report_mismatch("result with no request pending", out_rsih_value, 0);
        end else begin
          want = expected_rsi_q.pop_front();
          if (out_rsih_value !== want.rsih)
            report_mismatch("rsih_value", out_rsih_value, want.rsih);
          if (out_window_full !== want.full)
            report_mismatch("window_full", out_window_full, want.full);
        end
        checked_count++;
      end
      if (in_valid && !in_stall) predict_rsi(in_close_price);
    end
    pending_count <= expected_rsi_q.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WIN_LEN = 20;
  localparam int unsigned PRICE_W = 24;
  localparam longint PRICE_MAX = (64'd1 << PRICE_W) - 1;
  localparam int PHASE_ITEMS = 385;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PRICE_W-1:0]  in_close_price = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [15:0]  out_rsih_value;
  logic                out_window_full;
  int                  fail_count;
  int                  pending_count;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sent_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hann_windowed_rsi #(
    .WINDOW_LENGTH(WIN_LEN),
    .PRICE_BITS   (PRICE_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_close_price (in_close_price),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rsih_value (out_rsih_value),
    .out_window_full(out_window_full)
  );

  rsi_checker #(
    .WIN_LEN(WIN_LEN),
    .PRICE_W(PRICE_W)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_close_price (in_close_price),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rsih_value (out_rsih_value),
    .out_window_full(out_window_full),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < sink_stall_pct);

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_price(input longint price);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_close_price <= PRICE_W'(price);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic longint clamp_price(input longint p);
    if (p < 0) return 0;
    if (p > PRICE_MAX) return PRICE_MAX;
    return p;
  endfunction

  // trends long enough to fill the window reach all-up and all-down results
  task automatic run_phase(input int n_items);
    int     stop_at, kind, run_len;
    longint price, step_max, step;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(9);
      case ($urandom_range(3))
        0: price = 0;
        1: price = PRICE_MAX;
        default: price = $urandom_range(PRICE_MAX);
      endcase
      step_max = 64'd1 << $urandom_range(PRICE_W - 4);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          run_len = $urandom_range(WIN_LEN + 1, WIN_LEN + 12);
          if (kind < 3 && price == PRICE_MAX) price = 0;
          if (kind >= 3 && price == 0) price = PRICE_MAX;
          for (int i = 0; i < run_len; i++) begin
            send_price(price);
            step = $urandom_range(1, step_max);
            price = clamp_price(kind < 3 ? price + step : price - step);
          end
        end
        6: begin
          run_len = $urandom_range(2, WIN_LEN + 4);
          for (int i = 0; i < run_len; i++) send_price(price);
        end
        7, 8: begin
          run_len = $urandom_range(5, 40);
          for (int i = 0; i < run_len; i++) begin
            send_price(price);
            step = $urandom_range(0, step_max);
            price = clamp_price($urandom_range(1) ? price + step : price - step);
          end
        end
        default: begin
          run_len = $urandom_range(1, 8);
          for (int i = 0; i < run_len; i++) send_price($urandom_range(PRICE_MAX));
        end
      endcase
    end
  endtask

  initial begin
    longint directed_prices [] = '{
      0, 0, PRICE_MAX, PRICE_MAX, 0, 1, 0, 24'hAAAAAA, 24'h555555,
      24'h800000, 24'h7FFFFF, PRICE_MAX - 1, PRICE_MAX, 24'h000100, 24'h000100
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, flat (both sums zero) and single moves with a cold window
    foreach (directed_prices[i]) send_price(directed_prices[i]);

    run_phase(PHASE_ITEMS);
    // sender holds off until every pending request has produced its result
    wait_drained();

    src_idle_pct = 66;
    run_phase(PHASE_ITEMS);

    src_idle_pct = 0;
    sink_stall_pct = 66;
    run_phase(PHASE_ITEMS);
    wait_drained();

    src_idle_pct = 37;
    sink_stall_pct = 37;
    run_phase(PHASE_ITEMS);

    wait_drained();
    sink_stall_pct = 0;
    repeat (64) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/hwrsi_pkg.sv
src/hwrsi_div.sv
src/hann_windowed_rsi.sv
bench/rsi_checker.sv
bench/testbench.sv
